@@ rtl/bilinear_image_scaler_core_defines.svh @@
// ----------------------------------------------------------------------------
// Bilinear image scaler assertion macros
// Assertion helpers used by the scaler core; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_SCALER_CORE_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_CORE_DEFINES_SVH
`ifndef SYNTH
`define BIS_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("scaler assertion failed");
`define BIS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scaler assertion failed");
`else
`define BIS_ASSERT(label, cond)
`define BIS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/bis_pkg.sv @@
// ----------------------------------------------------------------------------
// Bilinear image scaler package
// Shared types and fixed constants of the scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

	localparam int ROW_BITS      = 9;
	localparam int COL_BITS      = 9;
	localparam int CHAN_BITS     = 8;
	localparam int SIZE_BITS     = 10;
	localparam int SCALE_BITS    = 24;
	localparam int POS_FRAC_BITS = 16;
	localparam int POS_BITS      = ROW_BITS + SCALE_BITS;
	localparam int BASE_BITS     = POS_BITS - POS_FRAC_BITS;
	localparam int PADDR_BITS    = 4;
	localparam int PDATA_BITS    = 32;

	localparam logic [SIZE_BITS-1:0]  WIDTH_RESET  = 10'd512;
	localparam logic [SIZE_BITS-1:0]  HEIGHT_RESET = 10'd512;
	localparam logic [SCALE_BITS-1:0] SCALE_RESET  = 24'd65536;
	localparam logic [CHAN_BITS-1:0]  FILL_VALUE   = 8'hFF;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REG_SOURCE_WIDTH  = 2'd0,
		REG_SOURCE_HEIGHT = 2'd1,
		REG_INVERSE_SCALE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		cmd_t                command;
		logic [ROW_BITS-1:0] pixel_row;
		logic [COL_BITS-1:0] pixel_col;
		logic [CHAN_BITS-1:0] chan_a;
		logic [CHAN_BITS-1:0] chan_b;
		logic [CHAN_BITS-1:0] chan_c;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] out_a;
		logic [CHAN_BITS-1:0] out_b;
		logic [CHAN_BITS-1:0] out_c;
		logic                 edge_fill;
	} out_item_t;

endpackage

@@ rtl/bis_ram.sv @@
// ----------------------------------------------------------------------------
// Bilinear image scaler RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bis_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/bilinear_image_scaler_core.sv @@
// ----------------------------------------------------------------------------
// Bilinear image scaler core
// Stores a source image and answers bilinear-interpolated output pixels.
// ----------------------------------------------------------------------------
// An item is taken on start; busy stays low, so one transfer is taken every
// cycle. A load writes one pixel into the frame store and gives no result. A
// query maps its output row and column through the inverse scale, reads the
// four neighbours and blends them. Its result appears on result with done
// high for one cycle, after the stage 1, stage 2 (store read), stage 3 and
// output registers, in item order. Throughput is one item per cycle: the
// store is four banks split by row and column parity, so the four neighbours
// come from four RAM read ports at once. Loads write at the same stage where
// queries read, so order is kept. Queries near the last row or column return
// white with edge_fill set. The APB port sets source width, height and inverse
// scale; the user writes them only while idle; the block does not enforce it.
// Reset clears the pipeline and registers; store contents are undefined until
// loaded. The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
`include "bilinear_image_scaler_core_defines.svh"

module bilinear_image_scaler_core
	import bis_pkg::*;
#(
	parameter int MAX_WIDTH   = 512,
	parameter int MAX_HEIGHT  = 512,
	parameter int WEIGHT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_item_t              item,
	output logic                  done,
	output out_item_t             result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready
);

	localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
	localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
	localparam int BANK_DEPTH = HALF_W * HALF_H;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int RA_BITS    = $clog2(MAX_HEIGHT);
	localparam int CA_BITS    = $clog2(MAX_WIDTH);
	localparam int CMP_BITS   = BASE_BITS + 1;
	localparam int WW         = WEIGHT_BITS + 1;
	localparam int PW         = 2 * WW;
	localparam int TW         = PW + CHAN_BITS;
	localparam int SW         = TW + 2;
	localparam int PIX_BITS   = 3 * CHAN_BITS;

	logic [SIZE_BITS-1:0]  width_q;
	logic [SIZE_BITS-1:0]  height_q;
	logic [SCALE_BITS-1:0] scale_q;
	logic                  wr_en;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			scale_q  <= SCALE_RESET;
		end else if (wr_en) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_SOURCE_WIDTH:  width_q  <= pwdata[SIZE_BITS-1:0];
				REG_SOURCE_HEIGHT: height_q <= pwdata[SIZE_BITS-1:0];
				REG_INVERSE_SCALE: scale_q  <= pwdata[SCALE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_SOURCE_WIDTH:  prdata = PDATA_BITS'(width_q);
			REG_SOURCE_HEIGHT: prdata = PDATA_BITS'(height_q);
			REG_INVERSE_SCALE: prdata = PDATA_BITS'(scale_q);
			default:           prdata = '0;
		endcase
	end

	// Stage 1: accepted item and scaled positions.
	logic                v_s1;
	in_item_t            item_s1;
	logic [POS_BITS-1:0] pos_r_s1;
	logic [POS_BITS-1:0] pos_c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		item_s1  <= item;
		pos_r_s1 <= POS_BITS'(item.pixel_row) * POS_BITS'(scale_q);
		pos_c_s1 <= POS_BITS'(item.pixel_col) * POS_BITS'(scale_q);
	end

	logic [BASE_BITS-1:0]   base_r;
	logic [BASE_BITS-1:0]   base_c;
	logic [CMP_BITS-1:0]    lim_w;
	logic [CMP_BITS-1:0]    lim_h;
	logic                   edge_hit;
	logic [WEIGHT_BITS-1:0] fr;
	logic [WEIGHT_BITS-1:0] fc;
	logic [WW-1:0]          wr0;
	logic [WW-1:0]          wc0;
	logic [RA_BITS-1:0]     br;
	logic [CA_BITS-1:0]     bc;
	logic [RA_BITS-1:0]     ld_row;
	logic [CA_BITS-1:0]     ld_col;
	logic                   ld_ok;
	logic [BANK_AW-1:0]     ld_addr;
	logic [BANK_AW-1:0]     bank_addr [4];
	logic                   bank_we [4];
	logic [PIX_BITS-1:0]    bank_rdata [4];
	logic [PIX_BITS-1:0]    ld_pix;

	assign base_r = pos_r_s1[POS_BITS-1:POS_FRAC_BITS];
	assign base_c = pos_c_s1[POS_BITS-1:POS_FRAC_BITS];
	assign fr     = pos_r_s1[POS_FRAC_BITS-1 -: WEIGHT_BITS];
	assign fc     = pos_c_s1[POS_FRAC_BITS-1 -: WEIGHT_BITS];
	assign wr0    = WW'(1 << WEIGHT_BITS) - WW'(fr);
	assign wc0    = WW'(1 << WEIGHT_BITS) - WW'(fc);

	assign lim_w = (CMP_BITS'(width_q) < CMP_BITS'(MAX_WIDTH))
		? CMP_BITS'(width_q) : CMP_BITS'(MAX_WIDTH);
	assign lim_h = (CMP_BITS'(height_q) < CMP_BITS'(MAX_HEIGHT))
		? CMP_BITS'(height_q) : CMP_BITS'(MAX_HEIGHT);
	assign edge_hit = (CMP_BITS'(base_r) + CMP_BITS'(1) >= lim_h)
		|| (CMP_BITS'(base_c) + CMP_BITS'(1) >= lim_w);

	assign br      = base_r[RA_BITS-1:0];
	assign bc      = base_c[CA_BITS-1:0];
	assign ld_row  = RA_BITS'(item_s1.pixel_row);
	assign ld_col  = CA_BITS'(item_s1.pixel_col);
	assign ld_ok   = (32'(item_s1.pixel_row) < MAX_HEIGHT)
		&& (32'(item_s1.pixel_col) < MAX_WIDTH);
	assign ld_addr = BANK_AW'((ld_row >> 1) * HALF_W + (ld_col >> 1));
	assign ld_pix  = {item_s1.chan_c, item_s1.chan_b, item_s1.chan_a};

	for (genvar i = 0; i < 4; i++) begin : g_bank
		logic [RA_BITS-1:0] rsel;
		logic [CA_BITS-1:0] csel;

		assign rsel = (br[0] == i[1]) ? br : br + RA_BITS'(1);
		assign csel = (bc[0] == i[0]) ? bc : bc + CA_BITS'(1);
		assign bank_addr[i] = (item_s1.command == CMD_LOAD) ? ld_addr
			: BANK_AW'((rsel >> 1) * HALF_W + (csel >> 1));
		assign bank_we[i] = v_s1 && (item_s1.command == CMD_LOAD) && ld_ok
			&& (ld_row[0] == i[1]) && (ld_col[0] == i[0]);

		bis_ram #(
			.WIDTH(PIX_BITS),
			.DEPTH(BANK_DEPTH)
		) u_bank (
			.clk  (clk),
			.we   (bank_we[i]),
			.waddr(bank_addr[i]),
			.wdata(ld_pix),
			.raddr(bank_addr[i]),
			.rdata(bank_rdata[i])
		);
	end

	// Stage 2: store data arrives; bilinear weights.
	logic          v_s2;
	logic          edge_s2;
	logic          br0_s2;
	logic          bc0_s2;
	logic [PW-1:0] w_s2 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && (item_s1.command == CMD_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		edge_s2 <= edge_hit;
		br0_s2  <= br[0];
		bc0_s2  <= bc[0];
		w_s2[0] <= PW'(wr0) * PW'(wc0);
		w_s2[1] <= PW'(wr0) * PW'(fc);
		w_s2[2] <= PW'(fr) * PW'(wc0);
		w_s2[3] <= PW'(fr) * PW'(fc);
	end

	logic [PIX_BITS-1:0] nb [4];

	assign nb[0] = bank_rdata[{br0_s2, bc0_s2}];
	assign nb[1] = bank_rdata[{br0_s2, !bc0_s2}];
	assign nb[2] = bank_rdata[{!br0_s2, bc0_s2}];
	assign nb[3] = bank_rdata[{!br0_s2, !bc0_s2}];

	// Stage 3: weighted terms per channel and neighbour.
	logic          v_s3;
	logic          edge_s3;
	logic [TW-1:0] term_s3 [3][4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		edge_s3 <= edge_s2;
		for (int ch = 0; ch < 3; ch++) begin
			for (int n = 0; n < 4; n++) begin
				term_s3[ch][n] <= TW'(nb[n][ch*CHAN_BITS +: CHAN_BITS]) * TW'(w_s2[n]);
			end
		end
	end

	// Output register.
	logic                 done_q;
	out_item_t            result_q;
	logic [SW-1:0]        sum [3];
	logic [CHAN_BITS-1:0] blend [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum[ch] = SW'(term_s3[ch][0]) + SW'(term_s3[ch][1])
				+ SW'(term_s3[ch][2]) + SW'(term_s3[ch][3]);
			blend[ch] = sum[ch][2*WEIGHT_BITS +: CHAN_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		result_q.out_a     <= edge_s3 ? FILL_VALUE : blend[0];
		result_q.out_b     <= edge_s3 ? FILL_VALUE : blend[1];
		result_q.out_c     <= edge_s3 ? FILL_VALUE : blend[2];
		result_q.edge_fill <= edge_s3;
	end

	assign done   = done_q;
	assign result = result_q;

	`BIS_ASSERT_NEXT(a_query_gives_result, v_s3, done)
	`BIS_ASSERT_NEXT(a_no_spurious_result, !v_s3, !done)
	`BIS_ASSERT(a_fill_is_white, !done || !result.edge_fill || (result.out_a == FILL_VALUE && result.out_b == FILL_VALUE && result.out_c == FILL_VALUE))
	`BIS_ASSERT_NEXT(a_load_no_query, v_s1 && (item_s1.command == CMD_LOAD), !v_s2)

endmodule
